FILE: rtl/mrcs_pkg.sv
// Package with the shared types, constants and CRC helper of the Modbus RTU coil slave.
`timescale 1ns / 1ps
package mrcs_pkg;

    localparam int BUFFER_BYTES = 256;
    localparam int NUM_COILS    = 16;
    localparam int REPLY_BYTES  = 256;

    localparam int RX_AW      = $clog2(BUFFER_BYTES);
    localparam int CNT_W      = $clog2(BUFFER_BYTES + 1);
    localparam int RP_AW      = $clog2(REPLY_BYTES);
    localparam int RP_LW      = $clog2(REPLY_BYTES + 1);
    localparam int COIL_IDX_W = (NUM_COILS > 1) ? $clog2(NUM_COILS) : 1;
    localparam int COIL_WORD_W = 16;

    localparam logic [1:0] FUNC_RX_BYTE = 2'd0;
    localparam logic [1:0] FUNC_TICK    = 2'd1;
    localparam logic [1:0] FUNC_TX_PULL = 2'd2;

    localparam logic [1:0] CFG_SLAVE_ADDRESS = 2'd0;
    localparam logic [1:0] CFG_FRAME_GAP     = 2'd1;

    localparam logic [7:0]  MB_READ_COILS  = 8'h01;
    localparam logic [7:0]  MB_WRITE_COIL  = 8'h05;
    localparam logic [7:0]  MB_BROADCAST   = 8'h00;
    localparam logic [15:0] MB_COIL_ON     = 16'hFF00;
    localparam logic [15:0] MB_MAX_READ    = 16'd2000;
    localparam logic [15:0] CRC_INIT       = 16'hFFFF;
    localparam logic [15:0] CRC_POLY       = 16'hA001;

    localparam logic [7:0]  SLAVE_ADDRESS_RESET = 8'd1;
    localparam logic [15:0] FRAME_GAP_RESET     = 16'd50;

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] rx_data;
    } in_item_t;

    typedef struct packed {
        logic                   tx_valid;
        logic [7:0]             tx_byte;
        logic                   tx_last;
        logic [COIL_WORD_W-1:0] coil_outputs;
    } out_item_t;

    typedef enum logic [1:0] {
        OP_RX_BYTE,
        OP_TICK,
        OP_TX_PULL,
        OP_NONE
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] data;
    } cmd_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_TX_READ,
        BK_BUILD,
        BK_COPY
    } back_state_t;

    // One byte of the reflected CRC16, bit by bit.
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] d);
        logic [15:0] c;
        c = crc ^ {8'h00, d};
        for (int b = 0; b < 8; b++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

FILE: rtl/mrcs_ram.sv
// Generic single write port RAM with a registered read port.
`timescale 1ns / 1ps
module mrcs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/mrcs_front.sv
// Front end: accepts requests, classifies them and queues them for the back end.
`timescale 1ns / 1ps
module mrcs_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  mrcs_pkg::in_item_t s_data,
    output logic              cmd_valid,
    output mrcs_pkg::cmd_t    cmd,
    input  logic              cmd_pop
);
    import mrcs_pkg::*;

    cmd_t       q_reg [2];
    logic       wptr_reg, wptr_next;
    logic       rptr_reg, rptr_next;
    logic [1:0] cnt_reg, cnt_next;
    cmd_t       in_cmd;
    logic       push;

    always_comb begin
        in_cmd.data = s_data.rx_data;
        case (s_data.func)
            FUNC_RX_BYTE: in_cmd.op = OP_RX_BYTE;
            FUNC_TICK:    in_cmd.op = OP_TICK;
            FUNC_TX_PULL: in_cmd.op = OP_TX_PULL;
            default:      in_cmd.op = OP_NONE;
        endcase
    end

    assign s_ready   = (cnt_reg != 2'd2);
    assign push      = s_valid && s_ready;
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd       = q_reg[rptr_reg];

    always_comb begin
        wptr_next = wptr_reg ^ push;
        rptr_next = rptr_reg ^ (cmd_pop && cmd_valid);
        cnt_next  = cnt_reg + {1'b0, push} - {1'b0, cmd_pop && cmd_valid};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end else begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wptr_reg] <= in_cmd;
        end
    end

    property p_no_pop_when_empty;
        @(posedge aclk) disable iff (!aresetn) cmd_pop |-> cmd_valid;
    endproperty
    a_no_pop_when_empty: assert property (p_no_pop_when_empty)
        else $error("front queue popped while empty");

    property p_count_bounded;
        @(posedge aclk) disable iff (!aresetn) cnt_reg != 2'd3;
    endproperty
    a_count_bounded: assert property (p_count_bounded)
        else $error("front queue count overflow");

    property p_pointers_track_count;
        @(posedge aclk) disable iff (!aresetn)
            (cnt_reg == 2'd1) |-> (wptr_reg != rptr_reg);
    endproperty
    a_pointers_track_count: assert property (p_pointers_track_count)
        else $error("front queue pointers disagree with count");

endmodule

FILE: rtl/mrcs_back.sv
// Back end: frame reception, frame handling, reply building and reply transmission.
`timescale 1ns / 1ps
module mrcs_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cmd_valid,
    input  mrcs_pkg::cmd_t      cmd,
    output logic                cmd_pop,
    input  logic [7:0]          slave_address,
    input  logic [15:0]         frame_gap_ticks,
    output logic                m_valid,
    input  logic                m_ready,
    output mrcs_pkg::out_item_t m_data
);
    import mrcs_pkg::*;

    back_state_t state_reg, state_next;

    logic [CNT_W-1:0]     rx_cnt_reg, rx_cnt_next;
    logic                 open_reg, open_next;
    logic [15:0]          sil_reg, sil_next;
    logic [NUM_COILS-1:0] coil_reg, coil_next;
    logic [7:0]           hdr_reg [6];
    logic [7:0]           hdr_next [6];
    logic [7:0]           b1_reg, b1_next, b2_reg, b2_next;
    logic [15:0]          crc_rx_reg, crc_rx_next;

    logic [RP_LW-1:0]     rp_len_reg, rp_len_next;
    logic [RP_LW-1:0]     rp_pos_reg, rp_pos_next;

    logic [RP_LW-1:0]     bidx_reg, bidx_next;
    logic [RP_LW-1:0]     blen_reg, blen_next;
    logic [7:0]           bbytes_reg, bbytes_next;
    logic [15:0]          bbase_reg, bbase_next;
    logic [10:0]          brem_reg, brem_next;
    logic [15:0]          crc_tx_reg, crc_tx_next;

    logic [RP_LW-1:0]     cidx_reg, cidx_next;
    logic [RP_LW-1:0]     clen_reg, clen_next;

    logic                 m_valid_reg, m_valid_next;
    out_item_t            m_data_reg, m_data_next;

    logic                 rx_we;
    logic [RX_AW-1:0]     rx_waddr, rx_raddr;
    logic [7:0]           rx_wdata, rx_rdata;
    logic                 rp_we;
    logic [RP_AW-1:0]     rp_waddr, rp_raddr;
    logic [7:0]           rp_wdata, rp_rdata;

    logic                 out_free;
    logic                 emit, e_valid, e_last;
    logic [7:0]           e_byte;
    logic [15:0]          sil_inc, start_w, qty_w, qty_round;
    logic                 frame_ok, bcast;
    logic [7:0]           build_byte, data_byte;
    logic [15:0]          bit_coil;
    logic [RP_LW-1:0]     cidx_prev;

    mrcs_ram #(.WIDTH(8), .DEPTH(BUFFER_BYTES)) u_rx_ram (
        .aclk  (aclk),
        .we    (rx_we),
        .waddr (rx_waddr),
        .wdata (rx_wdata),
        .raddr (rx_raddr),
        .rdata (rx_rdata)
    );

    mrcs_ram #(.WIDTH(8), .DEPTH(REPLY_BYTES)) u_reply_ram (
        .aclk  (aclk),
        .we    (rp_we),
        .waddr (rp_waddr),
        .wdata (rp_wdata),
        .raddr (rp_raddr),
        .rdata (rp_rdata)
    );

    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    assign start_w   = {hdr_reg[2], hdr_reg[3]};
    assign qty_w     = {hdr_reg[4], hdr_reg[5]};
    assign qty_round = qty_w + 16'd7;
    assign bcast     = (hdr_reg[0] == MB_BROADCAST);
    assign sil_inc   = (sil_reg == 16'hFFFF) ? sil_reg : sil_reg + 16'd1;
    assign frame_ok  = (rx_cnt_reg >= CNT_W'(8))
                    && (crc_rx_reg == {b1_reg, b2_reg})
                    && ((hdr_reg[0] == slave_address) || bcast);
    assign cidx_prev = cidx_reg - RP_LW'(1);

    // Packed data byte of a read-coils reply; bits past the quantity are zero.
    always_comb begin
        for (int b = 0; b < 8; b++) begin
            bit_coil = bbase_reg + 16'(b);
            data_byte[b] = (11'(b) < brem_reg) && (bit_coil < 16'(NUM_COILS))
                         && coil_reg[bit_coil[COIL_IDX_W-1:0]];
        end
    end

    always_comb begin
        if (bidx_reg == RP_LW'(0)) begin
            build_byte = slave_address;
        end else if (bidx_reg == RP_LW'(1)) begin
            build_byte = MB_READ_COILS;
        end else if (bidx_reg == RP_LW'(2)) begin
            build_byte = bbytes_reg;
        end else if (bidx_reg < blen_reg) begin
            build_byte = data_byte;
        end else if (bidx_reg == blen_reg) begin
            build_byte = crc_tx_reg[7:0];
        end else begin
            build_byte = crc_tx_reg[15:8];
        end
    end

    always_comb begin
        state_next   = state_reg;
        rx_cnt_next  = rx_cnt_reg;
        open_next    = open_reg;
        sil_next     = sil_reg;
        coil_next    = coil_reg;
        hdr_next     = hdr_reg;
        b1_next      = b1_reg;
        b2_next      = b2_reg;
        crc_rx_next  = crc_rx_reg;
        rp_len_next  = rp_len_reg;
        rp_pos_next  = rp_pos_reg;
        bidx_next    = bidx_reg;
        blen_next    = blen_reg;
        bbytes_next  = bbytes_reg;
        bbase_next   = bbase_reg;
        brem_next    = brem_reg;
        crc_tx_next  = crc_tx_reg;
        cidx_next    = cidx_reg;
        clen_next    = clen_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;

        cmd_pop  = 1'b0;
        emit     = 1'b0;
        e_valid  = 1'b0;
        e_byte   = 8'h00;
        e_last   = 1'b0;
        rx_we    = 1'b0;
        rx_waddr = rx_cnt_reg[RX_AW-1:0];
        rx_wdata = cmd.data;
        rx_raddr = cidx_reg[RX_AW-1:0];
        rp_we    = 1'b0;
        rp_waddr = bidx_reg[RP_AW-1:0];
        rp_wdata = build_byte;
        rp_raddr = rp_pos_reg[RP_AW-1:0];

        case (state_reg)
            BK_IDLE: begin
                if (cmd_valid && out_free) begin
                    cmd_pop = 1'b1;
                    case (cmd.op)
                        OP_RX_BYTE: begin
                            emit = 1'b1;
                            if (rx_cnt_reg < CNT_W'(BUFFER_BYTES)) begin
                                rx_we       = 1'b1;
                                rx_cnt_next = rx_cnt_reg + CNT_W'(1);
                                sil_next    = 16'd0;
                                open_next   = 1'b1;
                                for (int i = 0; i < 6; i++) begin
                                    if (rx_cnt_reg == CNT_W'(i)) begin
                                        hdr_next[i] = cmd.data;
                                    end
                                end
                                // CRC trails the stream by two bytes.
                                if (rx_cnt_reg == CNT_W'(0)) begin
                                    crc_rx_next = CRC_INIT;
                                end else if (rx_cnt_reg >= CNT_W'(2)) begin
                                    crc_rx_next = crc16_byte(crc_rx_reg, b2_reg);
                                end
                                b2_next = b1_reg;
                                b1_next = cmd.data;
                            end else begin
                                rx_cnt_next = '0;
                                open_next   = 1'b0;
                            end
                        end
                        OP_TICK: begin
                            emit = 1'b1;
                            if (open_reg && (rx_cnt_reg != '0)) begin
                                sil_next = sil_inc;
                                if (sil_inc >= frame_gap_ticks) begin
                                    rx_cnt_next = '0;
                                    open_next   = 1'b0;
                                    if (frame_ok && (hdr_reg[1] == MB_READ_COILS) && !bcast
                                        && (qty_w != 16'd0) && (qty_w <= MB_MAX_READ)) begin
                                        emit        = 1'b0;
                                        state_next  = BK_BUILD;
                                        bidx_next   = '0;
                                        bbytes_next = qty_round[10:3];
                                        blen_next   = RP_LW'(qty_round[10:3]) + RP_LW'(3);
                                        bbase_next  = start_w;
                                        brem_next   = qty_w[10:0];
                                        crc_tx_next = CRC_INIT;
                                    end else if (frame_ok && (hdr_reg[1] == MB_WRITE_COIL)) begin
                                        if (start_w < 16'(NUM_COILS)) begin
                                            coil_next[start_w[COIL_IDX_W-1:0]] =
                                                (qty_w == MB_COIL_ON);
                                        end
                                        if (!bcast) begin
                                            emit       = 1'b0;
                                            state_next = BK_COPY;
                                            cidx_next  = '0;
                                            clen_next  = RP_LW'(rx_cnt_reg);
                                        end
                                    end
                                end
                            end
                        end
                        OP_TX_PULL: begin
                            if (rp_pos_reg < rp_len_reg) begin
                                state_next = BK_TX_READ;
                            end else begin
                                emit = 1'b1;
                            end
                        end
                        default: begin
                            emit = 1'b1;
                        end
                    endcase
                end
            end
            BK_TX_READ: begin
                emit        = 1'b1;
                e_valid     = 1'b1;
                e_byte      = rp_rdata;
                e_last      = ((rp_pos_reg + RP_LW'(1)) == rp_len_reg);
                rp_pos_next = rp_pos_reg + RP_LW'(1);
                state_next  = BK_IDLE;
            end
            BK_BUILD: begin
                rp_we     = 1'b1;
                bidx_next = bidx_reg + RP_LW'(1);
                if (bidx_reg < blen_reg) begin
                    crc_tx_next = crc16_byte(crc_tx_reg, build_byte);
                end
                if ((bidx_reg >= RP_LW'(3)) && (bidx_reg < blen_reg)) begin
                    bbase_next = bbase_reg + 16'd8;
                    brem_next  = (brem_reg > 11'd8) ? brem_reg - 11'd8 : 11'd0;
                end
                if (bidx_reg == (blen_reg + RP_LW'(1))) begin
                    rp_len_next = blen_reg + RP_LW'(2);
                    rp_pos_next = '0;
                    state_next  = BK_IDLE;
                    emit        = 1'b1;
                end
            end
            BK_COPY: begin
                // Read runs one byte ahead of the write.
                rp_waddr = cidx_prev[RP_AW-1:0];
                rp_wdata = rx_rdata;
                rp_we    = (cidx_reg != '0);
                if (cidx_reg == clen_reg) begin
                    rp_len_next = clen_reg;
                    rp_pos_next = '0;
                    state_next  = BK_IDLE;
                    emit        = 1'b1;
                end else begin
                    cidx_next = cidx_reg + RP_LW'(1);
                end
            end
            default: begin
                state_next = BK_IDLE;
            end
        endcase

        if (emit) begin
            m_valid_next             = 1'b1;
            m_data_next.tx_valid     = e_valid;
            m_data_next.tx_byte      = e_byte;
            m_data_next.tx_last      = e_last;
            m_data_next.coil_outputs = COIL_WORD_W'(coil_next);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= BK_IDLE;
            rx_cnt_reg  <= '0;
            open_reg    <= 1'b0;
            sil_reg     <= 16'd0;
            coil_reg    <= '0;
            rp_len_reg  <= '0;
            rp_pos_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            rx_cnt_reg  <= rx_cnt_next;
            open_reg    <= open_next;
            sil_reg     <= sil_next;
            coil_reg    <= coil_next;
            rp_len_reg  <= rp_len_next;
            rp_pos_reg  <= rp_pos_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        hdr_reg    <= hdr_next;
        b1_reg     <= b1_next;
        b2_reg     <= b2_next;
        crc_rx_reg <= crc_rx_next;
        bidx_reg   <= bidx_next;
        blen_reg   <= blen_next;
        bbytes_reg <= bbytes_next;
        bbase_reg  <= bbase_next;
        brem_reg   <= brem_next;
        crc_tx_reg <= crc_tx_next;
        cidx_reg   <= cidx_next;
        clen_reg   <= clen_next;
        m_data_reg <= m_data_next;
    end

    property p_pos_within_len;
        @(posedge aclk) disable iff (!aresetn) rp_pos_reg <= rp_len_reg;
    endproperty
    a_pos_within_len: assert property (p_pos_within_len)
        else $error("reply position passed reply length");

    property p_open_has_bytes;
        @(posedge aclk) disable iff (!aresetn) open_reg |-> (rx_cnt_reg != '0);
    endproperty
    a_open_has_bytes: assert property (p_open_has_bytes)
        else $error("frame open with empty buffer");

    property p_idle_byte_is_zero;
        @(posedge aclk) disable iff (!aresetn)
            (m_valid_reg && !m_data_reg.tx_valid) |->
                (m_data_reg.tx_byte == 8'h00 && !m_data_reg.tx_last);
    endproperty
    a_idle_byte_is_zero: assert property (p_idle_byte_is_zero)
        else $error("result without reply byte carries data");

    property p_busy_output_empty;
        @(posedge aclk) disable iff (!aresetn)
            (state_reg == BK_BUILD || state_reg == BK_COPY) |-> !m_valid_reg;
    endproperty
    a_busy_output_empty: assert property (p_busy_output_empty)
        else $error("output slot filled while a frame is being handled");

endmodule

FILE: rtl/modbus_rtu_coil_slave_top.sv
// Top level of the Modbus RTU coil slave: configuration registers, front end and back end.
`timescale 1ns / 1ps
//
//  Channel   Direction  Handshake            Payload
//  s_        in         s_valid / s_ready    in_item_t  (func, rx_data)
//  m_        out        m_valid / m_ready    out_item_t (tx_valid, tx_byte, tx_last, coils)
//  cfg_      in         cfg_valid/cfg_ready  cfg_index (register), cfg_data (write data)
//
//  A received byte or a tick is handled in the idle state; a transmit pull with a reply
//  byte pending also passes the transmit-read state. The tick that closes a good
//  read-coils frame builds the reply, one reply byte written per cycle into the reply
//  memory; a write-coil echo copies the frame, one byte per cycle between the two memories.
//  Reset is synchronous and active low; it restores slave address 1 and a gap of 50.
//  The front queue absorbs two requests while a result waits; then s_ready drops.
module modbus_rtu_coil_slave_top (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  mrcs_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output mrcs_pkg::out_item_t m_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [15:0]         cfg_data
);
    import mrcs_pkg::*;

    // Station address and frame gap; writes are always taken at once.
    logic [7:0]  slave_address_reg, slave_address_next;
    logic [15:0] frame_gap_reg, frame_gap_next;

    logic cmd_valid;
    logic cmd_pop;
    cmd_t cmd;

    assign cfg_ready = 1'b1;

    always_comb begin
        slave_address_next = slave_address_reg;
        frame_gap_next     = frame_gap_reg;
        if (cfg_valid) begin
            case (cfg_index)
                CFG_SLAVE_ADDRESS: slave_address_next = cfg_data[7:0];
                CFG_FRAME_GAP:     frame_gap_next     = cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slave_address_reg <= SLAVE_ADDRESS_RESET;
            frame_gap_reg     <= FRAME_GAP_RESET;
        end else begin
            slave_address_reg <= slave_address_next;
            frame_gap_reg     <= frame_gap_next;
        end
    end

    // The front end decodes each request into a command and queues it.
    mrcs_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    // The back end owns the frame buffer, the coils and the reply memory.
    mrcs_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd_valid       (cmd_valid),
        .cmd             (cmd),
        .cmd_pop         (cmd_pop),
        .slave_address   (slave_address_reg),
        .frame_gap_ticks (frame_gap_reg),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_data          (m_data)
    );

endmodule
